// ===== rtl/tgarle_pkg.sv =====
// Shared types and constants for the TGA run-length pixel decoder.
package tgarle_pkg;

  // Configuration register indexes.
  localparam logic CFG_PIXEL_MODE  = 1'b0;
  localparam logic CFG_PIXEL_TOTAL = 1'b1;

  // Packet header layout.
  localparam logic [7:0] HDR_COUNT_MASK = 8'h7F;
  localparam logic [7:0] HDR_RUN_MASK   = 8'h80;

  // Pixel mode codes.
  localparam logic MODE_MONO = 1'b0;
  localparam logic MODE_BGR  = 1'b1;

  // Last byte position within a three-byte pixel.
  localparam logic [1:0] BGR_LAST_BYTE = 2'd2;

  typedef enum logic {
    ST_ITEM,
    ST_RUN
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_item;
    logic emit_run;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic item_starts_run;
    logic run_ending;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/tgarle_ctrl.sv =====
// Controller state machine: alternates between taking stream bytes and expanding runs.
module tgarle_ctrl
  import tgarle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ITEM;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    cmd.take_item = 1'b0;
    cmd.emit_run  = 1'b0;
    case (state)
      ST_ITEM: begin
        s_tready      = status.out_free;
        cmd.take_item = s_tvalid && status.out_free;
        if (cmd.take_item && status.item_starts_run) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.emit_run = status.out_free;
        if (cmd.emit_run && status.run_ending) begin
          state_next = ST_ITEM;
        end
      end
      default: begin
        state_next = ST_ITEM;
      end
    endcase
  end

endmodule

// ===== rtl/tgarle_dp.sv =====
// Datapath: configuration registers, packet decode state, run expansion and output register.
module tgarle_dp
  import tgarle_pkg::*;
#(
  parameter int PIXELS_PER_RESULT = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  output logic [55:0] m_tdata,
  output logic        m_tlast,
  output logic        m_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status
);

  localparam bit PairOk = (PIXELS_PER_RESULT >= 2);

  // Configuration.
  logic        pixel_mode;
  logic [31:0] pixel_total;

  // Decode state.
  logic        expect_header, expect_header_next;
  logic        packet_is_run, packet_is_run_next;
  logic [7:0]  packet_pixels_left, packet_pixels_left_next;
  logic [1:0]  byte_in_pixel, byte_in_pixel_next;
  logic [15:0] partial_pixel, partial_pixel_next;
  logic [31:0] pixels_emitted, pixels_emitted_next;
  logic        image_done, image_done_next;

  // Run expansion.
  logic [7:0]  run_left, run_left_next;
  logic [23:0] run_pixel;
  logic        run_complete;

  // Output register.
  logic [23:0] out_first, out_second;
  logic [1:0]  out_count;
  logic        out_last, out_done;

  // State as seen by the current byte, after a possible image restart.
  logic        e_exp, e_run, e_done;
  logic [7:0]  e_left;
  logic [1:0]  e_bip;
  logic [15:0] e_partial;
  logic [31:0] e_emitted;

  logic        finished, is_header, is_partial;
  logic [23:0] pix;
  logic [31:0] remaining;
  logic [7:0]  n_clip;
  logic        clip_done;
  logic [7:0]  left_dec;
  logic        raw_done;
  logic        load_raw, load_run;
  logic [1:0]  take;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode  <= MODE_BGR;
      pixel_total <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PIXEL_MODE:  pixel_mode  <= cfg_data[0];
        CFG_PIXEL_TOTAL: pixel_total <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    e_exp     = s_tuser ? 1'b1  : expect_header;
    e_run     = s_tuser ? 1'b0  : packet_is_run;
    e_done    = s_tuser ? 1'b0  : image_done;
    e_left    = s_tuser ? 8'd0  : packet_pixels_left;
    e_bip     = s_tuser ? 2'd0  : byte_in_pixel;
    e_partial = s_tuser ? 16'd0 : partial_pixel;
    e_emitted = s_tuser ? 32'd0 : pixels_emitted;

    finished   = e_done || (e_emitted >= pixel_total);
    is_header  = e_exp || (e_left == 8'd0);
    is_partial = (pixel_mode == MODE_BGR) && (e_bip < BGR_LAST_BYTE);

    if (pixel_mode == MODE_BGR) begin
      pix = {e_partial[7:0], e_partial[15:8], s_tdata};
    end else begin
      pix = {16'd0, s_tdata};
    end

    remaining = pixel_total - e_emitted;
    clip_done = ({24'd0, e_left} >= remaining);
    n_clip    = ({24'd0, e_left} > remaining) ? remaining[7:0] : e_left;
    left_dec  = e_left - 8'd1;
    raw_done  = (remaining == 32'd1);

    load_run = cmd.take_item && !finished && !is_header && !is_partial && e_run;
    load_raw = cmd.take_item && !finished && !is_header && !is_partial && !e_run;

    expect_header_next      = e_exp;
    packet_is_run_next      = e_run;
    packet_pixels_left_next = e_left;
    byte_in_pixel_next      = e_bip;
    partial_pixel_next      = e_partial;
    pixels_emitted_next     = e_emitted;
    image_done_next         = e_done;

    if (finished) begin
      image_done_next = 1'b1;
    end else if (is_header) begin
      packet_pixels_left_next = (s_tdata & HDR_COUNT_MASK) + 8'd1;
      packet_is_run_next      = (s_tdata & HDR_RUN_MASK) != 8'd0;
      expect_header_next      = 1'b0;
      byte_in_pixel_next      = 2'd0;
      partial_pixel_next      = 16'd0;
    end else if (is_partial) begin
      partial_pixel_next = e_partial | (e_bip[0] ? {s_tdata, 8'd0} : {8'd0, s_tdata});
      byte_in_pixel_next = e_bip + 2'd1;
    end else if (e_run) begin
      byte_in_pixel_next      = 2'd0;
      partial_pixel_next      = 16'd0;
      pixels_emitted_next     = e_emitted + {24'd0, n_clip};
      packet_pixels_left_next = 8'd0;
      expect_header_next      = 1'b1;
      image_done_next         = clip_done;
    end else begin
      byte_in_pixel_next      = 2'd0;
      partial_pixel_next      = 16'd0;
      pixels_emitted_next     = e_emitted + 32'd1;
      packet_pixels_left_next = left_dec;
      expect_header_next      = (left_dec == 8'd0);
      image_done_next         = raw_done;
    end

    // Run expansion: one or two copies per result.
    take          = (PairOk && (run_left >= 8'd2)) ? 2'd2 : 2'd1;
    run_left_next = run_left - {6'd0, take};

    status.item_starts_run = !finished && !is_header && !is_partial && e_run;
    status.run_ending      = (run_left_next == 8'd0);
    status.out_free        = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_header      <= 1'b1;
      packet_is_run      <= 1'b0;
      packet_pixels_left <= '0;
      byte_in_pixel      <= '0;
      partial_pixel      <= '0;
      pixels_emitted     <= '0;
      image_done         <= 1'b0;
    end else if (cmd.take_item) begin
      expect_header      <= expect_header_next;
      packet_is_run      <= packet_is_run_next;
      packet_pixels_left <= packet_pixels_left_next;
      byte_in_pixel      <= byte_in_pixel_next;
      partial_pixel      <= partial_pixel_next;
      pixels_emitted     <= pixels_emitted_next;
      image_done         <= image_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_left <= '0;
    end else if (load_run) begin
      run_left <= n_clip;
    end else if (cmd.emit_run) begin
      run_left <= run_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_run) begin
      run_pixel    <= pix;
      run_complete <= clip_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_raw || cmd.emit_run) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_raw) begin
      out_first  <= pix;
      out_second <= 24'd0;
      out_count  <= 2'd1;
      out_last   <= (left_dec == 8'd0) || raw_done;
      out_done   <= raw_done;
    end else if (cmd.emit_run) begin
      out_first  <= run_pixel;
      out_second <= (take == 2'd2) ? run_pixel : 24'd0;
      out_count  <= take;
      out_last   <= (run_left_next == 8'd0);
      out_done   <= (run_left_next == 8'd0) && run_complete;
    end
  end

  assign m_tdata = {6'd0, out_count, out_second, out_first};
  assign m_tlast = out_last;
  assign m_tuser = out_done;

endmodule

// ===== rtl/tga_rle_pixel_decoder.sv =====
// TGA run-length pixel decoder: top level joining the controller and the datapath.
// A raw pixel's result is presented in the cycle after its last byte is accepted; a run
// pixel's value is first held in the run registers and then copied to the output register.
// One stream byte is taken per cycle while results drain; a run (after clipping) holds the
// input while the run unit expands it, one result per cycle while the receiver takes them.
// Reset: synchronous, active high; clears decode state, the output valid and the config
// registers (pixel mode three-byte BGR, pixel total zero).
module tga_rle_pixel_decoder
  import tgarle_pkg::*;
#(
  parameter int PIXELS_PER_RESULT = 2
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel: index 0 is pixel_mode, index 1 is pixel_total.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  // Input stream, one compressed byte per request.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] stream_byte
  input  logic        s_tuser,   // [0] first_of_image
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [23:0] first_pixel, [47:24] second_pixel,
                                 // [49:48] pixels_valid, [55:50] zero
  output logic        m_tlast,   // last_of_packet
  output logic        m_tuser    // [0] image_complete
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Users write configuration only while the decoder is idle; not enforced, port always open.
  assign cfg_ready = 1'b1;

  // The controller decides when a byte is taken and when the run unit emits a result.
  tgarle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath decodes each accepted byte, holds the run being expanded and owns the
  // output register, so a byte is accepted while a result waits only if that result is taken.
  tgarle_dp #(
    .PIXELS_PER_RESULT (PIXELS_PER_RESULT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== tb/tb_tga_rle_pixel_decoder.sv =====
// Self-checking testbench for the TGA run-length pixel decoder: directed table, random images.
module tb_tga_rle_pixel_decoder;
  import tgarle_pkg::*;

  // Pixels per result; the block is built with the same value.
  localparam int PAIR = 2;
  // Quiet cycles after the last result before a register write or the final verdict.
  localparam int SETTLE_CYCLES = 6;
  // Long receiver hold-off that makes the block back up into its input.
  localparam int HOLD_CYCLES = 120;
  // Stream bytes wanted from the random part, and how many of them run without idling.
  localparam int RANDOM_BYTES = 120;
  localparam int CALM_BYTES = 30;
  // Slowest correct run: a few hundred bytes, each at worst a 128-pixel run of 64 results,
  // each result waiting out the longest random stall; the limit is several times that worst case.
  localparam int CYCLE_LIMIT = 500000;
  // Largest image, 65535 by 65535 pixels.
  localparam logic [31:0] TOTAL_MAX = 32'hFFFE0001;

  // One result as the block reports it; the field order matches {tdata fields, tlast, tuser}.
  typedef struct packed {
    logic [23:0] p0;
    logic [23:0] p1;
    logic [1:0]  cnt;
    logic        last;
    logic        done;
  } pix_result_t;

  // How a stimulus row is checked: by the predictor, or against a typed-in outcome of no
  // result or exactly one result.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_ONE
  } chk_t;

  typedef enum logic {
    ROW_BYTE,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        idx;
    logic [31:0] value;
    logic        first;
    chk_t        chk;
    pix_result_t res;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] stream_byte
  logic        s_tuser;   // [0] first_of_image
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;   // [23:0] first_pixel, [47:24] second_pixel, [49:48] pixels_valid
  logic        m_tlast;   // last_of_packet
  logic        m_tuser;   // [0] image_complete

  tga_rle_pixel_decoder #(
    .PIXELS_PER_RESULT(PAIR)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // Predictor copy of the configuration and the decode state.
  logic        px_mode;
  logic [31:0] px_total;
  logic        want_header;
  logic        in_run;
  logic [7:0]  pix_left;
  logic [1:0]  byte_pos;
  logic [15:0] partial_bg;   // blue in 7:0, green in 15:8
  logic [31:0] emitted;
  logic        img_done;

  // Results still owed by the block, oldest first.
  pix_result_t pending_pixels[$];
  stim_row_t   stim_rows[$];

  // Sideband that travels with each input request: how its results are to be checked.
  chk_t        row_chk;
  pix_result_t row_res;

  int error_count = 0;
  int cycle_count = 0;
  int bytes_taken = 0;
  int calm_mark = 32'h7FFFFFFF;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string msg);
    error_count++;
    if (error_count <= 100) $display("ERROR at cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic pix_result_t mk(input logic [23:0] p0, input logic [23:0] p1,
                                     input logic [1:0] cnt, input logic last,
                                     input logic done);
    pix_result_t r;
    r.p0 = p0;
    r.p1 = p1;
    r.cnt = cnt;
    r.last = last;
    r.done = done;
    return r;
  endfunction

  function automatic void clear_decode();
    want_header = 1'b1;
    in_run = 1'b0;
    pix_left = 8'd0;
    byte_pos = 2'd0;
    partial_bg = 16'd0;
    emitted = 32'd0;
    img_done = 1'b0;
  endfunction

  // Works out the results of one stream byte and queues them. A byte that arrives after the
  // image is complete is dropped with no result.
  function automatic void decode_byte(input logic [7:0] b, input logic first);
    int bpp;
    logic [23:0] pix;
    logic [31:0] remaining;
    logic [31:0] n;
    logic [31:0] take;
    bpp = (px_mode == MODE_BGR) ? 3 : 1;
    if (first) clear_decode();
    // A finished image swallows everything until the next image starts. This also covers a
    // total of zero and a total lowered below what was already sent.
    if (img_done || emitted >= px_total) begin
      img_done = 1'b1;
      return;
    end
    // A header opens a packet of 1 to 128 pixels.
    if (want_header || pix_left == 8'd0) begin
      pix_left = (b & HDR_COUNT_MASK) + 8'd1;
      in_run = (b & HDR_RUN_MASK) != 8'd0;
      want_header = 1'b0;
      byte_pos = 2'd0;
      partial_bg = 16'd0;
      return;
    end
    // Collect blue and green; the byte count follows the mode in force now, so a mode
    // change in the middle of a pixel ends the pixel early or late.
    if (int'(byte_pos) + 1 < bpp) begin
      partial_bg = partial_bg | ({8'h00, b} << (8 * byte_pos[0]));
      byte_pos = byte_pos + 2'd1;
      return;
    end
    if (bpp == 3) pix = {partial_bg[7:0], partial_bg[15:8], b};
    else pix = {16'h0000, b};
    byte_pos = 2'd0;
    partial_bg = 16'd0;
    remaining = px_total - emitted;
    if (in_run) begin
      // The run is cut to the pixels the image still lacks and sent out in pairs.
      n = {24'd0, pix_left};
      if (n > remaining) n = remaining;
      while (n > 0) begin
        take = (n < PAIR) ? n : PAIR;
        n = n - take;
        emitted = emitted + take;
        pending_pixels.push_back(mk(pix, (take == 2) ? pix : 24'd0, take[1:0], n == 0,
                                    emitted >= px_total));
      end
      pix_left = 8'd0;
      want_header = 1'b1;
    end else begin
      pix_left = pix_left - 8'd1;
      emitted = emitted + 32'd1;
      pending_pixels.push_back(mk(pix, 24'd0, 2'd1,
                                  (pix_left == 8'd0) || (emitted >= px_total),
                                  emitted >= px_total));
      if (pix_left == 8'd0) want_header = 1'b1;
    end
    if (emitted >= px_total) img_done = 1'b1;
  endfunction

  task automatic check_result(input pix_result_t got);
    pix_result_t want;
    if (pending_pixels.size() == 0) begin
      report($sformatf("result %h arrived with nothing expected", got));
      return;
    end
    want = pending_pixels.pop_front();
    if (got.p0 !== want.p0)
      report($sformatf("first_pixel %h, expected %h", got.p0, want.p0));
    if (got.p1 !== want.p1)
      report($sformatf("second_pixel %h, expected %h", got.p1, want.p1));
    if (got.cnt !== want.cnt)
      report($sformatf("pixels_valid %0d, expected %0d", got.cnt, want.cnt));
    if (got.last !== want.last)
      report($sformatf("last_of_packet %b, expected %b", got.last, want.last));
    if (got.done !== want.done)
      report($sformatf("image_complete %b, expected %b", got.done, want.done));
  endtask

  // Everything is sampled at the rising edge: results are checked, register writes and
  // accepted stream bytes update the predictor. A byte accepted at this edge cannot have a
  // result at the same edge, so checking first is safe.
  always @(posedge clk) begin : track
    int depth;
    if (rst) begin
      px_mode = MODE_BGR;
      px_total = 32'd0;
      clear_decode();
    end else begin
      if (m_tvalid && m_tready)
        check_result({m_tdata[23:0], m_tdata[47:24], m_tdata[49:48], m_tlast, m_tuser});
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PIXEL_MODE) px_mode = cfg_data[0];
        else px_total = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        depth = pending_pixels.size();
        decode_byte(s_tdata, s_tuser);
        bytes_taken++;
        // Rows with a typed-in outcome replace what the predictor queued for them; the
        // predictor still advances its state.
        if (row_chk != CHK_MODEL) begin
          while (pending_pixels.size() > depth) pending_pixels.delete(pending_pixels.size() - 1);
          if (row_chk == CHK_ONE) pending_pixels.push_back(row_res);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_pixels.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random stall bursts, one long hold-off on request, none near the end.
  initial begin : receiver
    int stall;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        stall = $urandom_range(1, 5);
        m_tready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // Offers one stream byte, after an occasional idle burst, and waits for the request to be
  // taken. Valid stays high afterwards until the next falling edge changes it.
  task automatic push_byte(input logic [7:0] b, input logic first, input chk_t chk,
                           input pix_result_t res);
    int gap;
    if (bytes_taken >= calm_mark) calm = 1'b1;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = b;
    s_tuser = first;
    row_chk = chk;
    row_res = res;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stops the stream and waits until every owed result is out and the block is quiet.
  task automatic settle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic void add_byte(input logic [7:0] b, input logic first, input chk_t chk,
                                   input pix_result_t res);
    stim_row_t r;
    r.kind = ROW_BYTE;
    r.idx = CFG_PIXEL_MODE;
    r.value = {24'd0, b};
    r.first = first;
    r.chk = chk;
    r.res = res;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input logic idx, input logic [31:0] value);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.value = value;
    r.chk = CHK_MODEL;
    stim_rows.push_back(r);
  endfunction

  // Directed part. Typed-in outcomes are used where they are plain to see.
  function automatic void build_table();
    // The total is zero after reset, so the image is finished before it starts.
    add_byte(8'h00, 1'b1, CHK_NONE, '0);
    add_cfg(CFG_PIXEL_TOTAL, 32'd4);
    add_cfg(CFG_PIXEL_MODE, {31'd0, MODE_MONO});
    // Mono run of two: one full pair.
    add_byte(8'h81, 1'b1, CHK_NONE, '0);
    add_byte(8'hFF, 1'b0, CHK_ONE, mk(24'h0000FF, 24'h0000FF, 2'd2, 1'b1, 1'b0));
    // Mono raw packet of two; its last pixel completes the image.
    add_byte(8'h01, 1'b0, CHK_NONE, '0);
    add_byte(8'h00, 1'b0, CHK_ONE, mk(24'h000000, 24'h000000, 2'd1, 1'b0, 1'b0));
    add_byte(8'h7F, 1'b0, CHK_ONE, mk(24'h00007F, 24'h000000, 2'd1, 1'b1, 1'b1));
    add_cfg(CFG_PIXEL_MODE, {31'd0, MODE_BGR});
    add_cfg(CFG_PIXEL_TOTAL, TOTAL_MAX);
    // BGR run of the largest count: 64 pairs.
    add_byte(8'hFF, 1'b1, CHK_NONE, '0);
    add_byte(8'h01, 1'b0, CHK_NONE, '0);
    add_byte(8'h02, 1'b0, CHK_NONE, '0);
    add_byte(8'h03, 1'b0, CHK_MODEL, '0);
    // BGR raw packet of one pixel, bytes reordered to R,G,B.
    add_byte(8'h00, 1'b0, CHK_NONE, '0);
    add_byte(8'hFF, 1'b0, CHK_NONE, '0);
    add_byte(8'h00, 1'b0, CHK_NONE, '0);
    add_byte(8'hAA, 1'b0, CHK_ONE, mk(24'hFF00AA, 24'h000000, 2'd1, 1'b1, 1'b0));
    // Raw packet of two, with the mode switched to mono after two bytes of the first pixel.
    add_byte(8'h01, 1'b0, CHK_NONE, '0);
    add_byte(8'h12, 1'b0, CHK_NONE, '0);
    add_byte(8'h34, 1'b0, CHK_NONE, '0);
    add_cfg(CFG_PIXEL_MODE, {31'd0, MODE_MONO});
    add_byte(8'h56, 1'b0, CHK_ONE, mk(24'h000056, 24'h000000, 2'd1, 1'b0, 1'b0));
    add_byte(8'h9A, 1'b0, CHK_MODEL, '0);
    // Total lowered below the pixels already sent: the image counts as finished.
    add_cfg(CFG_PIXEL_TOTAL, 32'd3);
    add_byte(8'h80, 1'b0, CHK_NONE, '0);
    // New image: a run of six clipped to three pixels.
    add_byte(8'h85, 1'b1, CHK_NONE, '0);
    add_byte(8'h11, 1'b0, CHK_MODEL, '0);
    // New image restarted in the middle of a raw packet, then a run of four clipped to three.
    add_byte(8'h01, 1'b1, CHK_NONE, '0);
    add_byte(8'hC3, 1'b0, CHK_MODEL, '0);
    add_byte(8'h83, 1'b1, CHK_NONE, '0);
    add_byte(8'hEE, 1'b0, CHK_MODEL, '0);
  endfunction

  // One random phase: new settings, then mostly well-formed packets with random content and
  // a little noise. The phase may stop in the middle of a packet or a pixel.
  task automatic random_image(input bit pressure);
    int budget;
    int pick;
    int bpp;
    int hdr_count;
    int nbytes;
    logic run_pkt;
    logic mode;
    logic first_hdr;
    logic [31:0] tot;
    if (pressure) begin
      mode = MODE_MONO;
      tot = TOTAL_MAX;
    end else begin
      mode = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      case (pick)
        0: tot = 32'd0;
        1: tot = TOTAL_MAX;
        2: tot = $urandom_range(0, TOTAL_MAX);
        default: tot = $urandom_range(1, 48);
      endcase
    end
    settle();
    write_reg(CFG_PIXEL_MODE, {31'd0, mode});
    write_reg(CFG_PIXEL_TOTAL, tot);
    if (pressure) hold_req = 1'b1;
    bpp = (mode == MODE_BGR) ? 3 : 1;
    budget = $urandom_range(10, 40);
    // Usually a new image; sometimes the previous one just carries on.
    first_hdr = ($urandom_range(0, 3) != 0);
    while (budget > 0) begin
      run_pkt = 1'($urandom_range(0, 1));
      hdr_count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 5);
      push_byte({run_pkt, hdr_count[6:0]}, first_hdr || ($urandom_range(0, 19) == 0),
                CHK_MODEL, '0);
      first_hdr = 1'b0;
      budget--;
      nbytes = run_pkt ? bpp : (hdr_count + 1) * bpp;
      while (nbytes > 0 && budget > 0) begin
        push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 39) == 0, CHK_MODEL, '0);
        nbytes--;
        budget--;
      end
    end
  endtask

  initial begin : stimulus
    int base;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = CFG_PIXEL_MODE;
    cfg_data = 32'd0;
    s_tvalid = 1'b0;
    s_tdata = 8'd0;
    s_tuser = 1'b0;
    row_chk = CHK_MODEL;
    row_res = '0;
    build_table();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(stim_rows[i].idx, stim_rows[i].value);
      end else begin
        push_byte(stim_rows[i].value[7:0], stim_rows[i].first, stim_rows[i].chk,
                  stim_rows[i].res);
      end
    end

    // Random part; the first phase carries the long hold-off on the result side.
    base = bytes_taken;
    calm_mark = base + RANDOM_BYTES - CALM_BYTES;
    random_image(1'b1);
    while (bytes_taken < base + RANDOM_BYTES) random_image(1'b0);

    settle();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
